[rtl/mpb_pkg.sv]
// Package for the MIDI pitch-bend parser.
// Holds the bend event type passed from the parser front end to the
// value formatter, and the configuration register indexes.
`timescale 1ns / 1ps

package mpb_pkg;

  // Configuration register indexes
  typedef enum logic {
    CFG_CHANNEL_SELECT = 1'b0,
    CFG_RAW_MODE       = 1'b1
  } cfg_index_t;

  // Byte classification constants
  localparam logic [3:0] BEND_STATUS_HI = 4'hE;  // 0xE0..0xEF
  localparam logic [4:0] REALTIME_HI    = 5'h1F; // 0xF8..0xFF

  // Channel select limits
  localparam logic [4:0] CHANNEL_MAX = 5'd16;

  // Normalization constants
  localparam logic [14:0] BEND_CENTER = 15'd8192;
  localparam logic [15:0] ROUND_BIAS  = 16'd8191;
  localparam logic [15:0] STEP_ONE    = 16'd16382;
  localparam logic [15:0] STEP_TWO    = 16'd32764;
  localparam logic [15:0] POS_LIMIT   = 16'd16383;
  localparam logic [15:0] NEG_LIMIT   = 16'd16384;

  // One complete bend message, as handed to the formatter
  typedef struct packed {
    logic [13:0] value;    // MSB*128 + LSB
    logic        omni;     // omni mode when the message completed
    logic [3:0]  chan;     // zero-based channel
    logic        raw;      // raw output selected
  } bend_event_t;

  // Handshake between a producer and a consumer of bend events
  typedef struct packed {
    logic        valid;
    bend_event_t ev;
  } bend_push_t;

endpackage

[rtl/mpb_front.sv]
// Parser front end: takes MIDI bytes, tracks running status and the
// stored LSB, and emits one bend event per completed message. Uses mpb_pkg.
`timescale 1ns / 1ps

module mpb_front
  import mpb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_midi_byte,
  input  logic       cfg_valid,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       q_full,
  output bend_push_t push
);

  logic [4:0] chsel_r, chsel_nxt;
  logic       raw_r, raw_nxt;
  logic       match_r, match_nxt;
  logic       lsb_rdy_r, lsb_rdy_nxt;
  logic [3:0] ch_held_r, ch_held_nxt;
  logic [6:0] lsb_r, lsb_nxt;

  logic       accept;
  logic       omni;
  logic [4:0] cfg_clamped;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign omni     = (chsel_r == 5'd0);
  assign cfg_clamped = (cfg_data > CHANNEL_MAX) ? CHANNEL_MAX : cfg_data;

  // Classify the byte and advance the parse state
  always_comb begin
    chsel_nxt   = chsel_r;
    raw_nxt     = raw_r;
    match_nxt   = match_r;
    lsb_rdy_nxt = lsb_rdy_r;
    ch_held_nxt = ch_held_r;
    lsb_nxt     = lsb_r;
    push.valid     = 1'b0;
    push.ev.value  = {in_midi_byte[6:0], lsb_r};
    push.ev.omni   = omni;
    push.ev.chan   = ch_held_r;
    push.ev.raw    = raw_r;

    if (accept) begin
      if (in_midi_byte[7]) begin
        // Status byte; real-time bytes pass untouched
        if (in_midi_byte[7:3] != REALTIME_HI) begin
          if (in_midi_byte[7:4] == BEND_STATUS_HI) begin
            if (omni) begin
              ch_held_nxt = in_midi_byte[3:0];
              match_nxt   = 1'b1;
            end else begin
              match_nxt   = (ch_held_r == in_midi_byte[3:0]);
            end
          end else begin
            match_nxt = 1'b0;
          end
          lsb_rdy_nxt = 1'b0;
        end
      end else if (lsb_rdy_r) begin
        // MSB completes the message
        push.valid  = 1'b1;
        lsb_rdy_nxt = 1'b0;
      end else if (match_r) begin
        // Hold the LSB until the MSB arrives
        lsb_nxt     = in_midi_byte[6:0];
        lsb_rdy_nxt = 1'b1;
      end
    end

    // Configuration writes
    if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_CHANNEL_SELECT: begin
          chsel_nxt = cfg_clamped;
          if (cfg_clamped != 5'd0) begin
            ch_held_nxt = 4'(cfg_clamped - 5'd1);
          end
        end
        CFG_RAW_MODE: begin
          raw_nxt = cfg_data[0];
        end
        default: begin
          raw_nxt = raw_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chsel_r   <= 5'd0;
      raw_r     <= 1'b0;
      match_r   <= 1'b0;
      lsb_rdy_r <= 1'b0;
      ch_held_r <= 4'd0;
      lsb_r     <= 7'd0;
    end else begin
      chsel_r   <= chsel_nxt;
      raw_r     <= raw_nxt;
      match_r   <= match_nxt;
      lsb_rdy_r <= lsb_rdy_nxt;
      ch_held_r <= ch_held_nxt;
      lsb_r     <= lsb_nxt;
    end
  end

endmodule

[rtl/mpb_queue.sv]
// Small FIFO of bend events between the parser front end and the
// formatter. Uses mpb_pkg for the event type.
`timescale 1ns / 1ps

module mpb_queue
  import mpb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  bend_push_t  push,
  output logic        full,
  output bend_push_t  head,
  input  logic        pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bend_event_t        mem_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && (count_r != '0);
  assign head       = {(count_r != '0), mem_r[rd_ptr_r]};

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.ev;
    end
  end

endmodule

[rtl/mpb_back.sv]
// Formatter back end: turns a bend event into the raw value or the
// rounded Q1.14 fraction and holds it in the output register. Uses mpb_pkg.
`timescale 1ns / 1ps

module mpb_back
  import mpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  bend_push_t         head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_bend_value,
  output logic [4:0]         out_channel_number,
  output logic               out_channel_valid
);

  logic               valid_r, valid_nxt;
  logic signed [14:0] value_r;
  logic [4:0]         chan_r;
  logic               chan_vld_r;

  logic               load;
  logic [14:0]        diff;
  logic               neg;
  logic [13:0]        mag;
  logic [15:0]        rnd;
  logic [15:0]        quo;
  logic [14:0]        norm;
  logic [14:0]        value_nxt;

  // Normalize: q = 2*mag + floor((4*mag + 8191) / 16382)
  always_comb begin
    diff = {1'b0, head.ev.value} - BEND_CENTER;
    neg  = diff[14];
    mag  = neg ? 14'(-diff) : diff[13:0];
    rnd  = {mag, 2'b00} + ROUND_BIAS;
    quo  = {1'b0, mag, 1'b0};
    if (rnd >= STEP_TWO) begin
      quo = quo + 16'd2;
    end else if (rnd >= STEP_ONE) begin
      quo = quo + 16'd1;
    end
    if (neg) begin
      norm = (quo >= NEG_LIMIT) ? 15'(-NEG_LIMIT) : 15'(-quo);
    end else begin
      norm = (quo > POS_LIMIT) ? POS_LIMIT[14:0] : quo[14:0];
    end
    value_nxt = head.ev.raw ? {1'b0, head.ev.value} : norm;
  end

  // Load the output register when it is empty or being taken
  assign load      = head.valid && (!valid_r || out_ready);
  assign pop       = load;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r    <= signed'(value_nxt);
      chan_r     <= head.ev.omni ? 5'({1'b0, head.ev.chan} + 5'd1) : 5'd0;
      chan_vld_r <= head.ev.omni;
    end
  end

  assign out_valid          = valid_r;
  assign out_bend_value     = value_r;
  assign out_channel_number = chan_r;
  assign out_channel_valid  = chan_vld_r;

endmodule

[rtl/midi_pitch_bend_parser.sv]
// Top level of the MIDI pitch-bend parser: parser front end, event queue
// and value formatter. Depends on mpb_pkg, mpb_front, mpb_queue, mpb_back.
`timescale 1ns / 1ps

// Takes one MIDI byte per cycle while in_ready is high and returns a
// result for each completed pitch-bend message on the selected channel (or
// any channel in omni mode), running status included. The result of a
// message is registered first in the event queue and then in the output
// register. The queue holds QUEUE_DEPTH events, so input keeps flowing
// while up to that many results wait behind a stalled output.
// Configuration writes are always ready; channel_select values above 16
// act as 16.
module midi_pitch_bend_parser
  import mpb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_midi_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_bend_value,
  output logic [4:0]         out_channel_number,
  output logic               out_channel_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data
);

  bend_push_t push;
  bend_push_t head;
  logic       q_full;
  logic       pop;

  assign cfg_ready = 1'b1;

  mpb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_midi_byte (in_midi_byte),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .push         (push)
  );

  mpb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  mpb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bend_value     (out_bend_value),
    .out_channel_number (out_channel_number),
    .out_channel_valid  (out_channel_valid)
  );

`ifndef SYNTHESIS
  // Omni results carry a one-based channel
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_channel_valid |->
      out_channel_number != 5'd0 && out_channel_number <= CHANNEL_MAX)
    else $error("omni result with channel out of range");

  // Single-channel results report channel zero
  a_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_channel_valid |-> out_channel_number == 5'd0)
    else $error("channel number given outside omni mode");

  // No result can leave in the cycle right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> !out_valid)
    else $error("result present right after reset");

  // Front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !q_full)
    else $error("bend event pushed into full queue");
`endif

endmodule
